/* hdl/hbridge_motor_ramp_controller_macros.svh */
// ----------------------------------------------------------------------------
// H-bridge ramp controller assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_MOTOR_RAMP_CONTROLLER_MACROS_SVH
`define HBRIDGE_MOTOR_RAMP_CONTROLLER_MACROS_SVH

// same-cycle implication
`define HMRC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HMRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hmrc_pkg.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller package
// Field widths, opcodes, drive modes, control types and duty scaling.
// ----------------------------------------------------------------------------
package hmrc_pkg;

    localparam int OPCODE_W   = 3;
    localparam int PCT_W      = 7;
    localparam int SECS_W     = 6;
    localparam int DUTY_W     = 8;
    localparam int INTERVAL_W = 15;
    localparam int COUNT_W    = 16;
    localparam int DIVIDEND_W = 16;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_COAST      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_BRAKE      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_STORE      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RUN_STORED = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RUN_GIVEN  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_JOG        = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RAMP       = 3'd7;

    localparam logic             KIND_UP       = 1'b0;
    localparam logic [COUNT_W-1:0]    JOG_RESET     = 16'd5000;
    localparam logic [COUNT_W-1:0]    COUNT_MAX     = 16'hFFFF;
    localparam logic [DUTY_W-1:0]     FULL_DUTY     = 8'd255;
    localparam logic [PCT_W-1:0]      FULL_PERCENT  = 7'd100;
    localparam logic [DIVIDEND_W-1:0] MS_PER_SECOND = 16'd1000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX  = 15'h7FFF;

    // 255 * ceil(2^19 / 100): floor(p*255/100) == (p * DUTY_RECIP) >> 19 for p <= 100
    localparam int unsigned DUTY_RECIP = 1336965;
    localparam int          DUTY_SHIFT = 19;
    localparam int          PROD_W     = 28;

    typedef enum logic [2:0] {
        MODE_COAST = 3'd0,
        MODE_BRAKE = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_JOG   = 3'd3,
        MODE_UP    = 3'd4,
        MODE_DOWN  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_start;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ramp_op;
        logic div_done;
    } t_sts;

    function automatic logic [DUTY_W-1:0] percent_to_duty(input logic [PCT_W-1:0] p);
        logic [PCT_W-1:0]  ps;
        logic [PROD_W-1:0] prod;
        ps   = (p > FULL_PERCENT) ? FULL_PERCENT : p;
        prod = PROD_W'(ps) * PROD_W'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

/* hdl/hmrc_in_if.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller command channel
// Valid/ready channel carrying one tick or command per beat.
// ----------------------------------------------------------------------------
interface hmrc_in_if import hmrc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic                ramp_kind;
    logic                direction;
    logic [PCT_W-1:0]    speed_percent;
    logic [SECS_W-1:0]   ramp_seconds;

    modport source (
        output valid, opcode, ramp_kind, direction, speed_percent, ramp_seconds,
        input  ready
    );

    modport sink (
        input  valid, opcode, ramp_kind, direction, speed_percent, ramp_seconds,
        output ready
    );

endinterface

/* hdl/hmrc_out_if.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller result channel
// Valid/ready channel carrying the bridge duties and busy flag per beat.
// ----------------------------------------------------------------------------
interface hmrc_out_if import hmrc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pin_a_duty;
    logic [DUTY_W-1:0] pin_b_duty;
    logic              busy_res;

    modport source (
        output valid, pin_a_duty, pin_b_duty, busy_res,
        input  ready
    );

    modport sink (
        input  valid, pin_a_duty, pin_b_duty, busy_res,
        output ready
    );

endinterface

/* hdl/hmrc_div.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller divider
// Restoring radix-2 divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module hmrc_div import hmrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DUTY_W-1:0]     i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DUTY_W-1:0]     r_rem;
    logic [DUTY_W-1:0]     r_divisor;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DUTY_W:0]       w_part;
    logic [DUTY_W:0]       w_diff;
    logic                  w_fit;

    assign w_part = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fit  = (w_part >= {1'b0, r_divisor});
    assign w_diff = w_part - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIVIDEND_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[DUTY_W-1:0] : w_part[DUTY_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* hdl/hmrc_ctrl.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller sequencer
// Accepts a beat, steps the datapath through execute, divide and write-back.
// ----------------------------------------------------------------------------
`include "hbridge_motor_ramp_controller_macros.svh"

module hmrc_ctrl import hmrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.ramp_op ? ST_DIV_START : ST_WRITE;
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                o_cmd.finish = i_sts.div_done;
            end
            ST_WRITE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `HMRC_ASSERT_IMPL(a_done_in_wait, i_sts.div_done, r_state == ST_DIV_WAIT, "divider done outside wait")
    `HMRC_ASSERT_IMPL(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten")
    `HMRC_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == ST_EXEC, "accept not executed")
    `HMRC_ASSERT_IMPL(a_start_after_exec, r_state == ST_DIV_START, $past(r_state) == ST_EXEC, "stray divide")

endmodule

/* hdl/hmrc_dp.sv */
// ----------------------------------------------------------------------------
// H-bridge ramp controller datapath
// Drive state, jog and ramp counters, ramp interval divide and result register.
// ----------------------------------------------------------------------------
module hmrc_dp import hmrc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic                i_ramp_kind,
    input  logic                i_direction,
    input  logic [PCT_W-1:0]    i_speed_percent,
    input  logic [SECS_W-1:0]   i_ramp_seconds,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    output logic [COUNT_W-1:0]  o_jog_ticks,
    output logic [DUTY_W-1:0]   o_pin_a_duty,
    output logic [DUTY_W-1:0]   o_pin_b_duty,
    output logic                o_busy_res
);

    logic [OPCODE_W-1:0]   r_op;
    logic                  r_kind;
    logic                  r_dir_in;
    logic [DUTY_W-1:0]     r_pct_duty;
    logic [DIVIDEND_W-1:0] r_secs_ms;

    logic [COUNT_W-1:0]    r_jog_ticks;
    logic                  r_drive_dir, n_drive_dir;
    logic [DUTY_W-1:0]     r_cur_duty, n_cur_duty;
    logic [DUTY_W-1:0]     r_stored_duty, n_stored_duty;
    t_mode                 r_mode, n_mode;
    logic [INTERVAL_W-1:0] r_step, n_step;
    logic [COUNT_W-1:0]    r_tick, n_tick;

    logic [DUTY_W-1:0]     r_pin_a, r_pin_b;
    logic                  r_busy;

    logic [DIVIDEND_W-1:0] w_quo;
    logic                  w_div_done;
    logic [INTERVAL_W-1:0] w_interval;
    logic [COUNT_W-1:0]    w_cnt_inc;
    logic [DUTY_W-1:0]     w_duty_up;
    logic [DUTY_W-1:0]     w_duty_dn;
    logic                  w_ramping;
    logic [DUTY_W-1:0]     w_pin_a, w_pin_b;
    logic                  w_busy;

    hmrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_secs_ms),
        .i_divisor  (r_stored_duty),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign o_sts.ramp_op  = (r_op == OP_RAMP);
    assign o_sts.div_done = w_div_done;

    assign w_interval = (r_stored_duty == '0) ? '0 :
                        (w_quo > DIVIDEND_W'(INTERVAL_MAX)) ? INTERVAL_MAX :
                        w_quo[INTERVAL_W-1:0];
    assign w_cnt_inc  = (r_tick == COUNT_MAX) ? r_tick : r_tick + 1'b1;
    assign w_duty_up  = (r_cur_duty == FULL_DUTY) ? r_cur_duty : r_cur_duty + 1'b1;
    assign w_duty_dn  = (r_cur_duty == '0) ? r_cur_duty : r_cur_duty - 1'b1;
    assign w_ramping  = (r_mode == MODE_UP) || (r_mode == MODE_DOWN);

    always_comb begin
        n_drive_dir   = r_drive_dir;
        n_cur_duty    = r_cur_duty;
        n_stored_duty = r_stored_duty;
        n_mode        = r_mode;
        n_step        = r_step;
        n_tick        = r_tick;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_TICK: begin
                    if (r_mode == MODE_JOG) begin
                        n_tick = w_cnt_inc;
                        if (w_cnt_inc >= r_jog_ticks) begin
                            n_mode     = MODE_COAST;
                            n_cur_duty = '0;
                            n_tick     = '0;
                        end
                    end else if (w_ramping) begin
                        n_tick = w_cnt_inc;
                        if (w_cnt_inc >= COUNT_W'(r_step)) begin
                            n_tick = '0;
                            if (r_mode == MODE_UP) begin
                                n_cur_duty = w_duty_up;
                                if (w_duty_up >= r_stored_duty) n_mode = MODE_RUN;
                            end else begin
                                n_cur_duty = w_duty_dn;
                                if (w_duty_dn == '0) n_mode = MODE_COAST;
                            end
                        end
                    end
                end
                OP_COAST: begin
                    n_mode     = MODE_COAST;
                    n_cur_duty = '0;
                    n_tick     = '0;
                end
                OP_BRAKE: begin
                    n_mode     = MODE_BRAKE;
                    n_cur_duty = '0;
                    n_tick     = '0;
                end
                OP_STORE: begin
                    n_stored_duty = r_pct_duty;
                    if ((r_mode == MODE_JOG) || w_ramping) begin
                        n_mode = MODE_RUN;
                        n_tick = '0;
                    end
                end
                OP_RUN_STORED, OP_RUN_GIVEN: begin
                    n_cur_duty  = (r_op == OP_RUN_STORED) ? r_stored_duty : r_pct_duty;
                    n_drive_dir = r_dir_in;
                    n_mode      = MODE_RUN;
                    n_tick      = '0;
                end
                OP_JOG: begin
                    n_cur_duty  = r_pct_duty;
                    n_drive_dir = r_dir_in;
                    n_mode      = MODE_JOG;
                    n_tick      = '0;
                end
                OP_RAMP: begin
                    n_tick = '0;
                    if (r_kind == KIND_UP) begin
                        n_stored_duty = r_pct_duty;
                        n_drive_dir   = r_dir_in;
                    end
                end
                default: begin
                    n_tick = r_tick;
                end
            endcase
        end else if (i_cmd.finish) begin
            n_step = w_interval;
            if (r_kind == KIND_UP) begin
                if (w_interval == '0) begin
                    n_cur_duty = r_stored_duty;
                    n_mode     = MODE_RUN;
                end else begin
                    n_cur_duty = '0;
                    n_mode     = MODE_UP;
                end
            end else begin
                if (w_interval == '0) begin
                    n_cur_duty = '0;
                    n_mode     = MODE_COAST;
                    n_tick     = '0;
                end else begin
                    n_cur_duty = r_stored_duty;
                    n_mode     = MODE_DOWN;
                end
            end
        end
    end

    always_comb begin
        w_pin_a = '0;
        w_pin_b = '0;
        w_busy  = 1'b0;
        unique case (r_mode)
            MODE_COAST: begin
                w_busy = 1'b0;
            end
            MODE_BRAKE: begin
                w_pin_a = FULL_DUTY;
                w_pin_b = FULL_DUTY;
            end
            MODE_RUN, MODE_JOG, MODE_UP, MODE_DOWN: begin
                if (r_drive_dir) w_pin_a = r_cur_duty;
                else             w_pin_b = r_cur_duty;
                w_busy = (r_mode != MODE_RUN);
            end
            default: begin
                w_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jog_ticks   <= JOG_RESET;
            r_drive_dir   <= 1'b0;
            r_cur_duty    <= '0;
            r_stored_duty <= '0;
            r_mode        <= MODE_COAST;
            r_step        <= '0;
            r_tick        <= '0;
        end else begin
            if (i_cfg_we) r_jog_ticks <= i_cfg_data;
            r_drive_dir   <= n_drive_dir;
            r_cur_duty    <= n_cur_duty;
            r_stored_duty <= n_stored_duty;
            r_mode        <= n_mode;
            r_step        <= n_step;
            r_tick        <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_opcode;
            r_kind     <= i_ramp_kind;
            r_dir_in   <= i_direction;
            r_pct_duty <= percent_to_duty(i_speed_percent);
            r_secs_ms  <= DIVIDEND_W'(i_ramp_seconds) * MS_PER_SECOND;
        end
        if (i_cmd.load_out) begin
            r_pin_a <= w_pin_a;
            r_pin_b <= w_pin_b;
            r_busy  <= w_busy;
        end
    end

    assign o_jog_ticks  = r_jog_ticks;
    assign o_pin_a_duty = r_pin_a;
    assign o_pin_b_duty = r_pin_b;
    assign o_busy_res   = r_busy;

endmodule

/* hdl/hbridge_motor_ramp_controller.sv */
// ----------------------------------------------------------------------------
// H-bridge motor ramp controller
// Drives the two PWM duties of an H-bridge from 1 ms ticks and commands.
//
// i_in carries one beat per tick or command; o_out returns exactly one beat
// per accepted input: pin A duty, pin B duty and the busy flag.
// Ticks and non-ramp commands pass through execute and write-back from accept
// to result; a soft start or smooth stop also passes through divide start and
// divide wait, where the restoring divider works out the ramp step interval.
// Input is taken only when the sequencer is idle, so a beat has left
// write-back before the next one is accepted.
// The result register holds its beat while o_out.ready is low; the next beat
// is accepted and worked on meanwhile and waits in write-back for the slot.
// The APB port holds jog_ticks where paddr[2] is 0; writes are taken in the
// access cycle, pready is always high.
// Synchronous active-low reset returns the drive to coast, clears stored
// speed and counters and sets jog_ticks to 5000.
// ----------------------------------------------------------------------------
module hbridge_motor_ramp_controller import hmrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hmrc_in_if.sink           i_in,
    hmrc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_cfg_we;
    logic [COUNT_W-1:0] w_jog_ticks;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? '0 : APB_DW'(w_jog_ticks);

    hmrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hmrc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_in.opcode),
        .i_ramp_kind     (i_in.ramp_kind),
        .i_direction     (i_in.direction),
        .i_speed_percent (i_in.speed_percent),
        .i_ramp_seconds  (i_in.ramp_seconds),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_data      (pwdata[COUNT_W-1:0]),
        .o_jog_ticks     (w_jog_ticks),
        .o_pin_a_duty    (o_out.pin_a_duty),
        .o_pin_b_duty    (o_out.pin_b_duty),
        .o_busy_res      (o_out.busy_res)
    );

endmodule
